/* rtl/ppu_pkg.sv */
// Package for the palette pair 2x upscaler: sizes, command and mode codes,
// and the result type. Used by the interfaces, the RAM users, the output
// queue, the top level and the checker.
package ppu_pkg;

	localparam int MAX_SRC_WIDTH = 1024;

	// source column counter, widened column and line store address
	localparam int CC_W       = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
	localparam int COL_W      = CC_W + 1;
	localparam int LINE_DEPTH = 2 * MAX_SRC_WIDTH;
	localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	localparam int OUT_COL_W = 11;
	localparam int COLX_W    = (COL_W > OUT_COL_W) ? COL_W : OUT_COL_W;

	localparam int PIX_W     = 8;
	localparam int TBL_DEPTH = 65536;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic CMD_TABLE = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic [1:0] MODE_WIDEN  = 2'd0;
	localparam logic [1:0] MODE_DOUBLE = 2'd1;
	localparam logic [1:0] MODE_BLEND  = 2'd2;

	localparam logic [1:0] CNT_ONE   = 2'd1;
	localparam logic [1:0] CNT_TWO   = 2'd2;
	localparam logic [1:0] CNT_THREE = 2'd3;

	typedef struct packed {
		logic [OUT_COL_W-1:0] out_column;
		logic [PIX_W-1:0]     line_a;
		logic [PIX_W-1:0]     line_b;
		logic [PIX_W-1:0]     line_c;
		logic [1:0]           line_count;
		logic                 run_last;
	} result_t;

endpackage

/* rtl/ppu_ifs.sv */
// Channel interfaces of the palette pair 2x upscaler: source items, results
// and the mode register write channel. Depends on ppu_pkg.
interface ppu_src_if import ppu_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [7:0]       first_index;
	logic [7:0]       second_index;
	logic [7:0]       blend_value;
	logic [PIX_W-1:0] pixel;
	logic             row_end;
	logic             final_row;

	modport source (output valid, cmd, first_index, second_index, blend_value, pixel,
		row_end, final_row, input ready);
	modport sink (input valid, cmd, first_index, second_index, blend_value, pixel,
		row_end, final_row, output ready);
endinterface

interface ppu_res_if import ppu_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OUT_COL_W-1:0] out_column;
	logic [PIX_W-1:0]     line_a;
	logic [PIX_W-1:0]     line_b;
	logic [PIX_W-1:0]     line_c;
	logic [1:0]           line_count;
	logic                 run_last;

	modport source (output valid, out_column, line_a, line_b, line_c, line_count,
		run_last, input ready);
	modport sink (input valid, out_column, line_a, line_b, line_c, line_count,
		run_last, output ready);
endinterface

interface ppu_cfg_if ();
	logic       valid;
	logic       ready;
	logic [1:0] scale_mode;

	modport source (output valid, scale_mode, input ready);
	modport sink (input valid, scale_mode, output ready);
endinterface

/* rtl/ppu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during write to the same address returns the old content. No deps.
module ppu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

/* rtl/ppu_out_fifo.sv */
// Result queue of the upscaler: holds finished results until the sink takes
// them and reports its fill level for issue credit. Depends on ppu_pkg, ppu_ifs.
module ppu_out_fifo import ppu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  result_t               push_data,
	output logic [FIFO_CNT_W-1:0] count,
	ppu_res_if.source             dst
);

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                 pop;
	result_t              head;

	assign pop   = dst.valid && dst.ready;
	assign count = cnt_q;
	assign head  = mem_q[rd_ptr_q];

	assign dst.valid      = (cnt_q != '0);
	assign dst.out_column = head.out_column;
	assign dst.line_a     = head.line_a;
	assign dst.line_b     = head.line_b;
	assign dst.line_c     = head.line_c;
	assign dst.line_count = head.line_count;
	assign dst.run_last   = head.run_last;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/palette_pair_2x_upscaler.sv */
// Palette pair 2x upscaler. A table write makes no column. A pixel item
// that completes a waiting pixel makes two widened columns; a row end adds
// two more, and a pixel that only waits makes none. Columns pass one per
// cycle, while issue is allowed, through the line store and the blend
// tables; each column's result goes through stages 1 and 2 and then
// sits in a four-entry queue. A column issues only when the queue has room for
// it and for everything still in flight, so a stalled sink holds the input off
// once four results are waiting or on their way.
// The blend table and the row store need no clearing pass after reset.
// Depends on ppu_pkg, ppu_ifs, ppu_ram and ppu_out_fifo.
module palette_pair_2x_upscaler import ppu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ppu_cfg_if.sink   cfg,
	ppu_src_if.sink   src,
	ppu_res_if.source dst
);

	logic [1:0] mode_q;

	// frame walk state
	logic [PIX_W-1:0] prior_pix_q;
	logic             waiting_q;
	logic [CC_W-1:0]  cc_q;
	logic             first_pend_q;

	// column sequencer
	logic             gen_valid_q;
	logic [1:0]       gen_step_q;
	logic [1:0]       gen_last_q;
	logic [PIX_W-1:0] gen_prior_q;
	logic [PIX_W-1:0] gen_pix_q;
	logic [CC_W-1:0]  gen_cc_q;
	logic [CC_W-1:0]  gen_cc2_q;
	logic             gen_final_q;
	logic             gen_emit_q;
	logic             gen_first_q;

	// stage 1: line store and first table read data
	logic             valid_s1;
	logic [COL_W-1:0] col_s1;
	logic             is_mix_s1;
	logic [PIX_W-1:0] vdir_s1;
	logic             final_s1;
	logic             emit_s1;
	logic             last_s1;
	logic             first_pend_s1;

	// stage 2: vertical blend data
	logic             valid_s2;
	logic [COL_W-1:0] col_s2;
	logic [PIX_W-1:0] v_s2;
	logic [PIX_W-1:0] above_s2;
	logic             final_s2;
	logic             emit_s2;
	logic             last_s2;
	logic             first_pend_s2;

	// delayed write into the second table copy
	logic             tblw_valid_s1;
	logic [15:0]      tblw_addr_s1;
	logic [PIX_W-1:0] tblw_data_s1;

	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic [FIFO_CNT_W:0]   credit_sum;
	logic                  issue_ok;
	logic                  issue;
	logic                  gen_done;
	logic                  acc;
	logic                  acc_pix;
	logic                  acc_tbl;
	logic [CC_W-1:0]       cc_next;
	logic [CC_W-1:0]       col_hi;
	logic [COL_W-1:0]      col_issue;
	logic [PIX_W-1:0]      vdir_issue;
	logic [PIX_W-1:0]      tbl_a_rdata;
	logic [PIX_W-1:0]      tbl_b_rdata;
	logic [PIX_W-1:0]      line_rdata;
	logic [PIX_W-1:0]      v_cur;
	logic [COLX_W-1:0]     colx;
	logic                  push;
	result_t               res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WIDEN;
		end else if (cfg.valid) begin
			mode_q <= cfg.scale_mode;
		end
	end

	// Results never stall the pipeline: a column issues only when the queue
	// has room for it and for everything still in flight.
	assign credit_sum = {1'b0, fifo_cnt} + (FIFO_CNT_W+1)'(valid_s1)
		+ (FIFO_CNT_W+1)'(valid_s2);
	assign issue_ok   = credit_sum < (FIFO_CNT_W+1)'(FIFO_DEPTH);
	assign issue      = gen_valid_q && issue_ok;
	assign gen_done   = issue && (gen_step_q == gen_last_q);

	assign src.ready = !gen_valid_q || gen_done;
	assign acc       = src.valid && src.ready;
	assign acc_pix   = acc && (src.cmd == CMD_PIXEL);
	assign acc_tbl   = acc && (src.cmd == CMD_TABLE);

	assign cc_next = (cc_q == CC_W'(MAX_SRC_WIDTH - 1)) ? '0 : cc_q + CC_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_pix_q  <= '0;
			waiting_q    <= 1'b0;
			cc_q         <= '0;
			first_pend_q <= 1'b1;
		end else if (acc_pix) begin
			if (src.row_end) begin
				cc_q         <= '0;
				waiting_q    <= 1'b0;
				first_pend_q <= src.final_row;
			end else begin
				prior_pix_q <= src.pixel;
				waiting_q   <= 1'b1;
				if (waiting_q) begin
					cc_q <= cc_next;
				end
			end
		end
	end

	// Steps 0 and 1 finish the waiting pixel, steps 2 and 3 close the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_valid_q <= 1'b0;
			gen_step_q  <= '0;
			gen_last_q  <= '0;
		end else if (acc_pix) begin
			gen_valid_q <= waiting_q || src.row_end;
			gen_step_q  <= waiting_q ? 2'd0 : 2'd2;
			gen_last_q  <= src.row_end ? 2'd3 : 2'd1;
		end else if (gen_done) begin
			gen_valid_q <= 1'b0;
		end else if (issue) begin
			gen_step_q <= gen_step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_pix) begin
			gen_prior_q <= prior_pix_q;
			gen_pix_q   <= src.pixel;
			gen_cc_q    <= cc_q;
			gen_cc2_q   <= waiting_q ? cc_next : cc_q;
			gen_final_q <= src.final_row;
			gen_emit_q  <= !((mode_q == MODE_BLEND) && first_pend_q && !src.final_row);
		end
	end

	assign col_hi    = gen_step_q[1] ? gen_cc2_q : gen_cc_q;
	assign col_issue = {col_hi, gen_step_q[0]};

	always_comb begin
		unique case (gen_step_q)
			2'd0:    vdir_issue = gen_prior_q;
			2'd2:    vdir_issue = gen_pix_q;
			default: vdir_issue = '0;
		endcase
	end

	// Copy A serves the horizontal blend at issue; copy B the vertical blend
	// in the cycle after, so its write is held in a register to keep order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tblw_valid_s1 <= 1'b0;
		end else begin
			tblw_valid_s1 <= acc_tbl;
		end
	end

	always_ff @(posedge clk) begin
		tblw_addr_s1 <= {src.first_index, src.second_index};
		tblw_data_s1 <= src.blend_value;
	end

	ppu_ram #(.WIDTH(PIX_W), .DEPTH(TBL_DEPTH)) u_tbl_a (
		.clk   (clk),
		.we    (acc_tbl),
		.waddr ({src.first_index, src.second_index}),
		.wdata (src.blend_value),
		.raddr ({gen_prior_q, gen_pix_q}),
		.rdata (tbl_a_rdata)
	);

	ppu_ram #(.WIDTH(PIX_W), .DEPTH(TBL_DEPTH)) u_tbl_b (
		.clk   (clk),
		.we    (tblw_valid_s1),
		.waddr (tblw_addr_s1),
		.wdata (tblw_data_s1),
		.raddr ({line_rdata, v_cur}),
		.rdata (tbl_b_rdata)
	);

	// Columns alternate even and odd, so the read at issue never meets the
	// write of the column just ahead of it.
	ppu_ram #(.WIDTH(PIX_W), .DEPTH(LINE_DEPTH)) u_line (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1[LINE_AW-1:0]),
		.wdata (v_cur),
		.raddr (col_issue[LINE_AW-1:0]),
		.rdata (line_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		col_s1    <= col_issue;
		is_mix_s1 <= (gen_step_q == 2'd1);
		vdir_s1   <= vdir_issue;
		final_s1  <= gen_final_q;
		emit_s1   <= gen_emit_q;
		last_s1   <= (gen_step_q == gen_last_q);

		col_s2   <= col_s1;
		v_s2     <= v_cur;
		above_s2 <= line_rdata;
		final_s2 <= final_s1;
		emit_s2  <= emit_s1;
		last_s2  <= last_s1;
	end

	assign v_cur = is_mix_s1 ? tbl_a_rdata : vdir_s1;

	assign colx = COLX_W'(col_s2);

	always_comb begin
		res.out_column = colx[OUT_COL_W-1:0];
		res.run_last   = last_s2;
		res.line_a     = v_s2;
		res.line_b     = '0;
		res.line_c     = '0;
		res.line_count = CNT_ONE;
		unique case (mode_q)
			MODE_DOUBLE: begin
				res.line_b     = v_s2;
				res.line_count = CNT_TWO;
			end
			MODE_BLEND: begin
				// hold the first row alone only when no row is stored yet
				if (!first_pend_s2) begin
					res.line_a     = above_s2;
					res.line_b     = tbl_b_rdata;
					res.line_count = CNT_TWO;
					if (final_s2) begin
						res.line_c     = v_s2;
						res.line_count = CNT_THREE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// first-row flag as seen by the item that issued this column
	always_ff @(posedge clk) begin
		if (acc_pix) begin
			gen_first_q <= first_pend_q;
		end
		first_pend_s1 <= gen_first_q;
		first_pend_s2 <= first_pend_s1;
	end

	assign push = valid_s2 && emit_s2;

	ppu_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.count     (fifo_cnt),
		.dst       (dst)
	);

endmodule

/* rtl/ppu_checker.sv */
// Port-level checker for the palette pair 2x upscaler and its bind to the
// top level. Depends on ppu_pkg and the top level's interface ports.
module ppu_checker import ppu_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [OUT_COL_W-1:0] out_column,
	input logic [PIX_W-1:0]     line_a,
	input logic [PIX_W-1:0]     line_b,
	input logic [PIX_W-1:0]     line_c,
	input logic [1:0]           line_count,
	input logic                 run_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_column) && $stable(line_a)
			&& $stable(line_b) && $stable(line_c) && $stable(line_count)
			&& $stable(run_last))
		else $error("result payload changed while stalled");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_count != 2'd0)
		else $error("result with no valid line");

	a_line_c_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_count != CNT_THREE |-> line_c == '0)
		else $error("line_c set on a result without a third line");

	a_line_b_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_count == CNT_ONE |-> line_b == '0)
		else $error("line_b set on a single-line result");

endmodule

bind palette_pair_2x_upscaler ppu_checker u_ppu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (dst.valid),
	.out_ready  (dst.ready),
	.out_column (dst.out_column),
	.line_a     (dst.line_a),
	.line_b     (dst.line_b),
	.line_c     (dst.line_c),
	.line_count (dst.line_count),
	.run_last   (dst.run_last)
);
